[hw/rtl/sensor_frame_builder_crc8_macros.svh]
`ifndef SENSOR_FRAME_BUILDER_CRC8_MACROS_SVH
`define SENSOR_FRAME_BUILDER_CRC8_MACROS_SVH

// Checks a condition on every clock edge outside reset.
`define SFB_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define SFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sfb_pkg.sv]
`timescale 1ns / 1ps
package sfb_pkg;

  localparam int MAX_SLOTS = 6;
  localparam int SLOT_W    = $clog2(MAX_SLOTS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SIGNATURE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT     = 1'd1;

  localparam logic [15:0] SIGNATURE_RESET = 16'hCAFE;
  localparam logic [7:0]  CRC_POLY        = 8'h8C;

  localparam logic signed [11:0] TEMP_LOW  = 12'sd160;
  localparam logic signed [11:0] TEMP_HIGH = 12'sd1600;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_SENSOR = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  // Reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

[hw/rtl/sfb_if.sv]
`timescale 1ns / 1ps
interface sfb_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [11:0] temp_sixteenths;
  logic              sensor_present;

  modport source (output valid, action, temp_sixteenths, sensor_present, input ready);
  modport sink   (input valid, action, temp_sixteenths, sensor_present, output ready);
endinterface

interface sfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

[hw/rtl/sfb_front.sv]
`timescale 1ns / 1ps
module sfb_front (
  input  logic          clk,
  input  logic          rst,
  sfb_item_if.sink      item,
  input  logic          q_full,
  output sfb_pkg::q_wr_t q_wr
);
  import sfb_pkg::*;

  logic [SLOT_W-1:0]  slots;
  logic [SLOT_W-1:0]  slots_next;
  logic               take;
  logic signed [11:0] diff;
  logic               in_range;
  logic [7:0]         reading;

  assign item.ready = !q_full;
  assign take       = item.valid && !q_full;

  assign diff     = item.temp_sixteenths - TEMP_LOW;
  assign in_range = (item.temp_sixteenths > TEMP_LOW) && (item.temp_sixteenths < TEMP_HIGH);
  assign reading  = in_range ? diff[10:3] : 8'd0;

  always_comb begin
    slots_next      = slots;
    q_wr.push       = 1'b0;
    q_wr.cmd.kind   = CMD_DATA;
    q_wr.cmd.data   = reading;
    unique case (item.action)
      ACT_BEGIN: begin
        q_wr.push     = take;
        q_wr.cmd.kind = CMD_HEADER;
        if (take) slots_next = '0;
      end
      ACT_SENSOR: begin
        if (take && item.sensor_present && (slots < SLOT_W'(MAX_SLOTS))) begin
          q_wr.push  = 1'b1;
          slots_next = slots + SLOT_W'(1);
        end
      end
      ACT_END: begin
        q_wr.push     = take;
        q_wr.cmd.kind = CMD_END;
        if (take) slots_next = '0;
      end
      default: begin
        q_wr.push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= '0;
    end else begin
      slots <= slots_next;
    end
  end

endmodule

[hw/rtl/sfb_queue.sv]
`timescale 1ns / 1ps
`include "sensor_frame_builder_crc8_macros.svh"
module sfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  sfb_pkg::q_wr_t q_wr,
  output logic           full,
  input  logic           pop,
  output sfb_pkg::q_rd_t q_rd
);
  import sfb_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign push      = q_wr.push && !full;
  assign q_rd.valid = (count != '0);
  assign q_rd.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= q_wr.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `SFB_ASSERT(a_no_pop_empty, !pop || q_rd.valid, "pop from empty queue")
  `SFB_ASSERT(a_no_push_full, !q_wr.push || !full, "word dropped on full queue")
  `SFB_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + QCNT_W'(1), "count lost a push")
  `SFB_ASSERT_NEXT(a_ptr_gap, 1'b1, QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0], "pointers disagree with count")

endmodule

[hw/rtl/sfb_back.sv]
`timescale 1ns / 1ps
module sfb_back (
  input  logic           clk,
  input  logic           rst,
  input  sfb_pkg::q_rd_t q_rd,
  output logic           pop,
  input  logic [15:0]    device_signature,
  input  logic [2:0]     sensor_count,
  sfb_frame_if.source    frame
);
  import sfb_pkg::*;

  localparam logic [1:0] HDR_SIG_HI = 2'd0;
  localparam logic [1:0] HDR_SIG_LO = 2'd1;
  localparam logic [1:0] HDR_COUNT  = 2'd2;

  logic [1:0] hdr;
  logic [1:0] hdr_next;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic       ob_valid;
  logic [7:0] ob_byte;
  logic       ob_last;
  logic       load;
  logic [7:0] ld_byte;
  logic       ld_last;
  logic [7:0] crc_base;

  assign load = q_rd.valid && (!ob_valid || frame.ready);

  always_comb begin
    hdr_next = hdr;
    ld_byte  = q_rd.cmd.data;
    ld_last  = 1'b0;
    crc_base = crc;
    pop      = 1'b0;
    unique case (q_rd.cmd.kind)
      CMD_HEADER: begin
        unique case (hdr)
          HDR_SIG_HI: begin
            ld_byte  = device_signature[15:8];
            crc_base = 8'd0;
            hdr_next = HDR_SIG_LO;
          end
          HDR_SIG_LO: begin
            ld_byte  = device_signature[7:0];
            hdr_next = HDR_COUNT;
          end
          HDR_COUNT: begin
            ld_byte  = {5'd0, sensor_count};
            hdr_next = HDR_SIG_HI;
            pop      = load;
          end
          default: begin
            hdr_next = HDR_SIG_HI;
          end
        endcase
      end
      CMD_DATA: begin
        pop = load;
      end
      CMD_END: begin
        ld_byte = crc;
        ld_last = 1'b1;
        pop     = load;
      end
      default: begin
        pop = load;
      end
    endcase
    crc_next = (q_rd.cmd.kind == CMD_END) ? crc : crc8_update(crc_base, ld_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr      <= HDR_SIG_HI;
      crc      <= 8'd0;
      ob_valid <= 1'b0;
    end else begin
      if (load) begin
        ob_valid <= 1'b1;
        crc      <= crc_next;
        if (q_rd.cmd.kind == CMD_HEADER) hdr <= hdr_next;
      end else if (frame.ready) begin
        ob_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_byte <= ld_byte;
      ob_last <= ld_last;
    end
  end

  assign frame.valid      = ob_valid;
  assign frame.frame_byte = ob_byte;
  assign frame.last_byte  = ob_last;

endmodule

[hw/rtl/sensor_frame_builder_crc8.sv]
// Path: an accepted word is written into the command queue, then loads into the output
// register that drives the frame; earlier entries or a stalled sink keep it queued.
// Throughput: one input word per cycle unless the queue is full; sensor and end words
// give at most one byte, a begin word gives three bytes through the output register.
// The four-entry command queue lets input run ahead of the byte output.
// Reset (rst, synchronous): CRC and slot count cleared, queue and output emptied,
// signature back to 0xCAFE and sensor count to 0.
`timescale 1ns / 1ps
module sensor_frame_builder_crc8 (
  input  logic                             clk,
  input  logic                             rst,
  sfb_item_if.sink                         item,
  sfb_frame_if.source                      frame,
  input  logic                             cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfb_pkg::*;

  logic [15:0] device_signature;
  logic [2:0]  sensor_count;
  q_wr_t       q_wr;
  q_rd_t       q_rd;
  logic        q_full;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_signature <= SIGNATURE_RESET;
      sensor_count     <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_SIGNATURE: device_signature <= cfg_data[15:0];
        CFG_SENSOR_COUNT:     sensor_count     <= cfg_data[2:0];
        default:              sensor_count     <= sensor_count;
      endcase
    end
  end

  sfb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  sfb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .full (q_full),
    .pop  (pop),
    .q_rd (q_rd)
  );

  sfb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_rd             (q_rd),
    .pop              (pop),
    .device_signature (device_signature),
    .sensor_count     (sensor_count),
    .frame            (frame)
  );

endmodule

[verif/tb_sensor_frame_builder_crc8.sv]
`timescale 1ns / 1ps
module tb_sensor_frame_builder_crc8;
  import sfb_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [7:0] MAXIM_POLY   = 8'h8C;
  localparam int         RANDOM_WORDS = 230;
  localparam int         SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfb_item_if  item_ch ();
  sfb_frame_if frame_ch ();

  sensor_frame_builder_crc8 DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .frame     (frame_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [15:0] signature_shadow;
  logic [2:0]  count_shadow;
  logic [7:0]  frame_crc;
  int          readings_in_frame;

  frame_byte_t frame_bytes_due[$];
  int          mismatches;
  int          rx_hold_req;
  int          burst_left;
  int          words_offered;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL sensor_frame_builder_crc8");
    $finish;
  end

  function automatic logic [7:0] maxim_crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ MAXIM_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] reading_code(input logic signed [11:0] t);
    int v;
    v = t;
    if (v <= 160 || v >= 1600) begin
      return 8'd0;
    end
    return 8'((v - 160) >>> 3);
  endfunction

  function automatic void push_body_byte(input logic [7:0] b);
    frame_byte_t fb;
    fb.data = b;
    fb.last = 1'b0;
    frame_crc = maxim_crc_byte(frame_crc, b);
    frame_bytes_due.push_back(fb);
  endfunction

  function automatic void predict_frame_bytes(input logic [1:0] act,
                                              input logic signed [11:0] t,
                                              input logic p);
    frame_byte_t fb;
    case (act)
      ACT_BEGIN: begin
        frame_crc = 8'h00;
        readings_in_frame = 0;
        push_body_byte(signature_shadow[15:8]);
        push_body_byte(signature_shadow[7:0]);
        push_body_byte({5'd0, count_shadow});
      end
      ACT_SENSOR: begin
        if (p && readings_in_frame < MAX_SLOTS) begin
          push_body_byte(reading_code(t));
          readings_in_frame++;
        end
      end
      ACT_END: begin
        fb.data = frame_crc;
        fb.last = 1'b1;
        frame_bytes_due.push_back(fb);
        readings_in_frame = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [11:0] random_temp();
    case ($urandom_range(4))
      0: return 12'($urandom);
      1: return 12'($urandom_range(150, 175));
      2: return 12'($urandom_range(1590, 1610));
      default: return 12'($urandom_range(161, 1599));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected frame byte %02h (last %0b)", frame_ch.frame_byte, frame_ch.last_byte);
        mismatches++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_ch.frame_byte !== want.data) begin
          $error("frame_byte: expected %02h, got %02h", want.data, frame_ch.frame_byte);
          mismatches++;
        end
        if (frame_ch.last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, frame_ch.last_byte);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern; a hold request overrides it
  initial begin : rx_pattern
    int run_left;
    int stall_pct;
    run_left = 0;
    stall_pct = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          run_left = $urandom_range(5, 40);
        end
        run_left--;
        frame_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic signed [11:0] t,
                           input logic p);
    item_ch.valid          <= 1'b1;
    item_ch.action         <= act;
    item_ch.temp_sixteenths <= t;
    item_ch.sensor_present <= p;
    do @(posedge clk); while (!item_ch.ready);
    predict_frame_bytes(act, t, p);
  endtask

  task automatic pause_sender(input int n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // send in bursts with random gaps
  task automatic offer(input logic [1:0] act, input logic signed [11:0] t, input logic p);
    send_word(act, t, p);
    if (act != ACT_UNUSED) begin
      words_offered++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_config(input logic [15:0] sig, input logic [2:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_SIGNATURE;
    cfg_data  <= sig;
    @(posedge clk);
    cfg_index <= CFG_SENSOR_COUNT;
    cfg_data  <= {13'd0, cnt};
    @(posedge clk);
    cfg_we <= 1'b0;
    signature_shadow = sig;
    count_shadow = cnt;
    @(posedge clk);
  endtask

  task automatic test_no_begin();
    offer(ACT_SENSOR, 12'sd800, 1'b1);
    offer(ACT_SENSOR, 12'sd400, 1'b0);
    offer(ACT_END, 12'sd0, 1'b0);
  endtask

  task automatic test_reset_header();
    offer(ACT_BEGIN, 12'sd0, 1'b0);
    offer(ACT_END, 12'sd0, 1'b0);
  endtask

  // range limits, ignored action, absent sensor and slot overflow
  task automatic test_reading_limits();
    offer(ACT_BEGIN, 12'sd0, 1'b1);
    offer(ACT_SENSOR, -12'sd2048, 1'b1);
    offer(ACT_SENSOR, 12'sd160, 1'b1);
    offer(ACT_SENSOR, 12'sd161, 1'b1);
    offer(ACT_UNUSED, 12'($urandom), 1'b1);
    offer(ACT_SENSOR, 12'sd1599, 1'b1);
    offer(ACT_SENSOR, 12'sd1600, 1'b1);
    offer(ACT_SENSOR, 12'sd2047, 1'b1);
    offer(ACT_SENSOR, 12'sd168, 1'b1);
    offer(ACT_SENSOR, 12'sd300, 1'b0);
    offer(ACT_END, 12'sd0, 1'b0);
  endtask

  // register extremes, repeated end, readings after end
  task automatic test_register_extremes();
    wait_drained();
    set_frame_config(16'h0000, 3'd0);
    offer(ACT_BEGIN, 12'sd0, 1'b0);
    offer(ACT_END, 12'sd0, 1'b0);
    wait_drained();
    set_frame_config(16'hFFFF, 3'd7);
    offer(ACT_BEGIN, 12'sd0, 1'b0);
    offer(ACT_SENSOR, 12'sd1599, 1'b1);
    offer(ACT_END, 12'sd0, 1'b0);
    offer(ACT_END, 12'sd0, 1'b0);
    offer(ACT_SENSOR, 12'sd500, 1'b1);
    offer(ACT_END, 12'sd0, 1'b0);
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_output_hold();
    wait_drained();
    set_frame_config(16'($urandom), 3'd6);
    rx_hold_req = 60;
    send_word(ACT_BEGIN, 12'sd0, 1'b0);
    repeat (6) send_word(ACT_SENSOR, random_temp(), 1'b1);
    send_word(ACT_END, 12'sd0, 1'b0);
    send_word(ACT_BEGIN, 12'sd0, 1'b0);
    send_word(ACT_SENSOR, random_temp(), 1'b1);
    send_word(ACT_END, 12'sd0, 1'b0);
    pause_sender(1);
  endtask

  // sender waits for every byte before going on
  task automatic test_sender_pause();
    offer(ACT_BEGIN, 12'sd0, 1'b0);
    offer(ACT_SENSOR, random_temp(), 1'b1);
    wait_drained();
    offer(ACT_SENSOR, random_temp(), 1'b1);
    offer(ACT_END, 12'sd0, 1'b0);
  endtask

  task automatic test_random_frames();
    int phase;
    int n;
    phase = 0;
    words_offered = 0;
    while (words_offered < RANDOM_WORDS) begin
      if (words_offered >= (phase + 1) * 60) begin
        phase++;
        wait_drained();
        case (phase % 4)
          0: set_frame_config(16'($urandom), 3'($urandom_range(0, 6)));
          1: set_frame_config(16'h0000, 3'd0);
          2: set_frame_config(16'hFFFF, 3'd7);
          default: set_frame_config(16'($urandom), 3'd6);
        endcase
      end
      if ($urandom_range(99) < 80) begin
        offer(ACT_BEGIN, 12'($urandom), 1'($urandom));
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(19) == 0) begin
            offer(ACT_UNUSED, 12'($urandom), 1'($urandom));
          end
          offer(ACT_SENSOR, random_temp(), $urandom_range(99) < 85);
        end
        if ($urandom_range(9) != 0) begin
          offer(ACT_END, 12'($urandom), 1'($urandom));
        end
      end else begin
        offer(2'($urandom_range(0, 3)), 12'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    mismatches = 0;
    rx_hold_req = 0;
    burst_left = 0;
    words_offered = 0;
    signature_shadow = SIGNATURE_RESET;
    count_shadow = 3'd0;
    frame_crc = 8'h00;
    readings_in_frame = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.action <= ACT_BEGIN;
    item_ch.temp_sixteenths <= 12'sd0;
    item_ch.sensor_present <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_begin();
    test_reset_header();
    test_reading_limits();
    test_register_extremes();
    test_output_hold();
    test_sender_pause();
    test_random_frames();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("PASS sensor_frame_builder_crc8");
    end else begin
      $display("FAIL sensor_frame_builder_crc8");
    end
    $finish;
  end

endmodule
